// ----- design/union_find_engine_core_defines.svh -----
// Assertion macros shared by the union-find engine.
`ifndef UNION_FIND_ENGINE_CORE_DEFINES_SVH
`define UNION_FIND_ENGINE_CORE_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define UF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define UF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/uf_pkg.sv -----
// Shared types and constants for the union-find engine.
package uf_pkg;

    localparam int NODE_W = 10;

    typedef logic [NODE_W-1:0] t_node;

endpackage

// ----- design/uf_mem.sv -----
// Parent table memory: one write port, one registered read port with write forwarding.
module uf_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [AW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [AW-1:0] o_rdata
);

    logic [AW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/union_find_engine_core.sv -----
// Union-find engine top level: sequencer that walks and compresses the parent table.
//
// After reset the block writes every table entry to point at itself, with busy
// high; no request is taken during that pass. A request is taken when start is
// high and busy is low. Each request gives exactly one result, shown for one
// cycle with o_valid high; the receiver cannot stall it. A request whose node is
// out of range answers in the next cycle and leaves busy low. Otherwise the
// sequencer follows parent links through the registered-read table memory, one
// link per cycle, then walks the path again rewriting each entry to its root,
// first for node_a and then for node_b, and finally links the two roots.
`include "union_find_engine_core_defines.svh"

module union_find_engine_core #(
    parameter int NODES = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  uf_pkg::t_node   i_node_a,
    input  uf_pkg::t_node   i_node_b,
    output logic            o_valid,
    output logic            o_merged,
    output uf_pkg::t_node   o_set_root
);

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND,
        S_COMP,
        S_LINK
    } t_state;

    t_state        r_state, n_state;
    logic          r_side, n_side;
    logic [AW-1:0] r_node_a, n_node_a;
    logic [AW-1:0] r_node_b, n_node_b;
    logic [AW-1:0] r_cur, n_cur;
    logic [AW-1:0] r_root, n_root;
    logic [AW-1:0] r_ra, n_ra;
    logic [AW-1:0] r_rb, n_rb;
    logic [AW-1:0] r_clr, n_clr;
    logic          r_valid, n_valid;
    logic          r_merged, n_merged;
    uf_pkg::t_node r_set_root, n_set_root;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_wdata;
    logic [AW-1:0] w_raddr;
    logic [AW-1:0] w_rdata;
    logic          w_end;
    logic [AW-1:0] w_end_root;
    logic [AW-1:0] w_node;
    logic          w_in_range;

    uf_mem #(
        .DEPTH (NODES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_in_range = (32'(i_node_a) < NODES) && (32'(i_node_b) < NODES);
    assign w_node     = r_side ? r_node_b : r_node_a;

    always_comb begin
        n_state    = r_state;
        n_side     = r_side;
        n_node_a   = r_node_a;
        n_node_b   = r_node_b;
        n_cur      = r_cur;
        n_root     = r_root;
        n_ra       = r_ra;
        n_rb       = r_rb;
        n_clr      = r_clr;
        n_valid    = 1'b0;
        n_merged   = r_merged;
        n_set_root = r_set_root;
        w_we       = 1'b0;
        w_waddr    = r_cur;
        w_wdata    = r_root;
        w_raddr    = r_cur;
        w_end      = 1'b0;
        w_end_root = r_root;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = r_clr;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (w_in_range) begin
                        n_node_a = AW'(i_node_a);
                        n_node_b = AW'(i_node_b);
                        n_cur    = AW'(i_node_a);
                        w_raddr  = AW'(i_node_a);
                        n_side   = 1'b0;
                        n_state  = S_FIND;
                    end else begin
                        n_valid    = 1'b1;
                        n_merged   = 1'b0;
                        n_set_root = '0;
                    end
                end
            end
            S_FIND: begin
                if (w_rdata == r_cur) begin
                    n_root = r_cur;
                    if (w_node == r_cur) begin
                        w_end      = 1'b1;
                        w_end_root = r_cur;
                    end else begin
                        n_cur   = w_node;
                        w_raddr = w_node;
                        n_state = S_COMP;
                    end
                end else begin
                    n_cur   = w_rdata;
                    w_raddr = w_rdata;
                end
            end
            S_COMP: begin
                w_we    = 1'b1;
                w_waddr = r_cur;
                w_wdata = r_root;
                if (w_rdata == r_root) begin
                    w_end      = 1'b1;
                    w_end_root = r_root;
                end else begin
                    n_cur   = w_rdata;
                    w_raddr = w_rdata;
                end
            end
            S_LINK: begin
                w_we       = (r_ra != r_rb);
                w_waddr    = r_rb;
                w_wdata    = r_ra;
                n_valid    = 1'b1;
                n_merged   = (r_ra != r_rb);
                n_set_root = uf_pkg::t_node'(r_ra);
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_end) begin
            if (!r_side) begin
                n_ra    = w_end_root;
                n_side  = 1'b1;
                n_cur   = r_node_b;
                w_raddr = r_node_b;
                n_state = S_FIND;
            end else begin
                n_rb    = w_end_root;
                n_state = S_LINK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
            r_side  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
            r_side  <= n_side;
        end
        r_node_a   <= n_node_a;
        r_node_b   <= n_node_b;
        r_cur      <= n_cur;
        r_root     <= n_root;
        r_ra       <= n_ra;
        r_rb       <= n_rb;
        r_merged   <= n_merged;
        r_set_root <= n_set_root;
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_merged   = r_merged;
    assign o_set_root = r_set_root;

    `UF_ASSERT_NEXT(a_accept_progress, start && !busy, busy || o_valid, "request was dropped")
    `UF_ASSERT_SAME(a_comp_not_root, r_state == S_COMP, w_we && (w_waddr != r_root), "root written")
    `UF_ASSERT_SAME(a_find_no_write, r_state == S_FIND, !w_we, "table written during root search")

endmodule
